[rtl/acps_pkg.sv]
// Shared types, register codes and colour mixing for the antialiased circle shader.
// No dependencies; the files that use it refer to it by scoped names.
package acps_pkg;

    localparam int COORD_W = 12;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    localparam logic [16:0] ALPHA_MIN = 17'd655;

    localparam logic [2:0] REG_CENTER_X      = 3'd0;
    localparam logic [2:0] REG_CENTER_Y      = 3'd1;
    localparam logic [2:0] REG_RADIUS        = 3'd2;
    localparam logic [2:0] REG_THICKNESS     = 3'd3;
    localparam logic [2:0] REG_FILL_ARGB     = 3'd4;
    localparam logic [2:0] REG_BORDER_ARGB   = 3'd5;
    localparam logic [2:0] REG_PAINT_ENABLES = 3'd6;
    localparam logic [2:0] REG_PIXEL_ORDER   = 3'd7;

    localparam logic [1:0] MODE_FILL   = 2'd0;
    localparam logic [1:0] MODE_BORDER = 2'd1;
    localparam logic [1:0] MODE_BOTH   = 2'd2;

    typedef struct packed {
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] radius;
        logic [7:0]  thick;
        logic [31:0] fill;
        logic [31:0] border;
        logic [1:0]  enables;
        logic        order;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [31:0]        bg;
        logic               go;
        logic [1:0]         mode;
    } side_t;

    // (k*a + (1-k)*b) >> 16 with k in Q16
    function automatic logic [7:0] mix_byte(input logic [16:0] k, input logic [7:0] a,
                                            input logic [7:0] b);
        logic [24:0] s;
        s = 25'(k) * 25'(a) + 25'(ALPHA_ONE - k) * 25'(b);
        return s[23:16];
    endfunction

endpackage

[rtl/acps_dist.sv]
// Distance front end: bounding box, squared distance and pipelined integer square root.
// Depends on acps_pkg.
module acps_dist #(
    parameter int COORD_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  acps_pkg::side_t              in_side,
    input  acps_pkg::cfg_t               cfg,
    output logic                         out_valid,
    output acps_pkg::side_t              out_side,
    output logic signed [COORD_BITS+9:0] out_d
);
    localparam int CW = (COORD_BITS < 12) ? COORD_BITS : 12;
    localparam int AW = COORD_BITS + 8;
    localparam int SW = 2 * AW + 1;
    localparam int NS = COORD_BITS + 9;

    logic [COORD_BITS-1:0] px, py, cx, cy, rad, adx, ady;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0] lim;
    logic [AW-1:0] ax_next, ay_next, ax_reg, ay_reg;
    logic fill_on, border_on;
    acps_pkg::side_t side0_next;

    assign px  = COORD_BITS'(in_side.x);
    assign py  = COORD_BITS'(in_side.y);
    assign cx  = COORD_BITS'(cfg.cx[CW-1:0]);
    assign cy  = COORD_BITS'(cfg.cy[CW-1:0]);
    assign rad = COORD_BITS'(cfg.radius[CW-1:0]);
    assign dx  = $signed({1'b0, px}) - $signed({1'b0, cx});
    assign dy  = $signed({1'b0, py}) - $signed({1'b0, cy});
    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    assign lim = {1'b0, rad} + (COORD_BITS+1)'(2);
    assign ax_next = dx[COORD_BITS] ? {adx - COORD_BITS'(1), 8'h80} : {adx, 8'h80};
    assign ay_next = dy[COORD_BITS] ? {ady - COORD_BITS'(1), 8'h80} : {ady, 8'h80};
    assign fill_on   = cfg.enables[0];
    assign border_on = cfg.enables[1] && (cfg.thick != 8'd0);

    always_comb begin
        side0_next = in_side;
        side0_next.go = (fill_on || border_on) && ({1'b0, adx} <= lim) && ({1'b0, ady} <= lim);
        if (border_on && fill_on) begin
            side0_next.mode = acps_pkg::MODE_BOTH;
        end else if (border_on) begin
            side0_next.mode = acps_pkg::MODE_BORDER;
        end else begin
            side0_next.mode = acps_pkg::MODE_FILL;
        end
    end

    logic v0_reg, v1_reg;
    acps_pkg::side_t side0_reg, side1_reg;
    logic [2*AW-1:0] sqx_reg, sqy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side0_reg <= side0_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            side1_reg <= side0_reg;
            sqx_reg   <= (2*AW)'(ax_reg) * (2*AW)'(ax_reg);
            sqy_reg   <= (2*AW)'(ay_reg) * (2*AW)'(ay_reg);
        end
    end

    logic [SW-1:0]   sv_reg   [0:NS];
    logic [SW:0]     sr_reg   [0:NS];
    logic            sval_reg [0:NS];
    acps_pkg::side_t sside_reg[0:NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sval_reg[0] <= 1'b0;
        end else if (en) begin
            sval_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sv_reg[0]    <= SW'(sqx_reg) + SW'(sqy_reg);
            sr_reg[0]    <= '0;
            sside_reg[0] <= side1_reg;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_root
        localparam int K = NS - 1 - s;
        logic [SW:0]   bit_w, sum_w, r_next;
        logic [SW-1:0] v_next;

        assign bit_w = (SW+1)'(1) << (2 * K);
        assign sum_w = sr_reg[s] + bit_w;

        always_comb begin
            if ({1'b0, sv_reg[s]} >= sum_w) begin
                v_next = SW'({1'b0, sv_reg[s]} - sum_w);
                r_next = (sr_reg[s] >> 1) + bit_w;
            end else begin
                v_next = sv_reg[s];
                r_next = sr_reg[s] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sval_reg[s+1] <= 1'b0;
            end else if (en) begin
                sval_reg[s+1] <= sval_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sv_reg[s+1]    <= v_next;
                sr_reg[s+1]    <= r_next;
                sside_reg[s+1] <= sside_reg[s];
            end
        end
    end

    logic [NS-1:0] root;
    logic signed [COORD_BITS+9:0] d_next, d_reg;
    logic dv_reg;
    acps_pkg::side_t dside_reg;

    assign root   = sr_reg[NS][NS-1:0];
    assign d_next = $signed({1'b0, root}) - $signed({2'b00, rad, 8'h00});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
        end else if (en) begin
            dv_reg <= sval_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg     <= d_next;
            dside_reg <= sside_reg[NS];
        end
    end

    assign out_valid = dv_reg;
    assign out_side  = dside_reg;
    assign out_d     = d_reg;

endmodule

[rtl/acps_cover.sv]
// Coverage stage: smoothstep inputs, pipelined divider for the border ring, smoothstep products.
// Depends on acps_pkg.
module acps_cover #(
    parameter int COORD_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  acps_pkg::side_t              in_side,
    input  logic signed [COORD_BITS+9:0] in_d,
    input  acps_pkg::cfg_t               cfg,
    output logic                         out_valid,
    output acps_pkg::side_t              out_side,
    output logic [16:0]                  out_cov,
    output logic [16:0]                  out_bf
);
    localparam int DW = COORD_BITS + 10;
    localparam int NW = DW + 2;
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [16:0]     tf;
        logic [16:0]     tb;
        logic            over;
        logic [8:0]      den;
        logic [7:0]      nlo;
        logic [8:0]      rem;
        logic [15:0]     q;
        acps_pkg::side_t side;
    } dcar_t;

    function automatic logic [16:0] clamp_t(input logic signed [NW-1:0] n);
        if (n <= NW'(0)) begin
            return 17'd0;
        end else if (n >= NW'(256)) begin
            return acps_pkg::ALPHA_ONE;
        end else begin
            return {1'b0, n[7:0], 8'h00};
        end
    endfunction

    logic [DW-1:0] dabs;
    logic signed [NW-1:0] numf_next, numb_next, numf_reg, numb_reg;
    logic [NW-1:0] numo_next, numo_reg;
    logic c0v_reg;
    acps_pkg::side_t c0side_reg;
    logic [8:0] den_next, den_reg;

    assign dabs      = in_d[DW-1] ? DW'(-in_d) : DW'(in_d);
    assign numf_next = NW'(in_d) + NW'(128);
    assign numb_next = NW'(in_d) + $signed(NW'({cfg.thick, 8'h80}));
    assign numo_next = NW'(dabs) + NW'({cfg.thick, 7'h00}) + NW'(8'd128);
    assign den_next  = {1'b0, cfg.thick} + 9'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0v_reg <= 1'b0;
        end else if (en) begin
            c0v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            numf_reg   <= numf_next;
            numb_reg   <= numb_next;
            numo_reg   <= numo_next;
            den_reg    <= den_next;
            c0side_reg <= in_side;
        end
    end

    dcar_t car_reg [0:DIV_STEPS];
    logic  cv_reg  [0:DIV_STEPS];
    dcar_t car0_next;

    always_comb begin
        car0_next.tf   = clamp_t(numf_reg);
        car0_next.tb   = clamp_t(numb_reg);
        car0_next.over = numo_reg >= NW'({den_reg, 8'h00});
        car0_next.den  = den_reg;
        car0_next.nlo  = numo_reg[7:0];
        car0_next.rem  = {1'b0, numo_reg[15:8]};
        car0_next.q    = '0;
        car0_next.side = c0side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= c0v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car_reg[0] <= car0_next;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int I = DIV_STEPS - 1 - s;
        logic [15:0] dl;
        logic [9:0]  trial;
        dcar_t       nx;

        assign dl    = {car_reg[s].nlo, 8'h00};
        assign trial = {car_reg[s].rem, dl[I]};

        always_comb begin
            nx = car_reg[s];
            if (trial >= {1'b0, car_reg[s].den}) begin
                nx.rem = 9'(trial - {1'b0, car_reg[s].den});
                nx.q   = car_reg[s].q | (16'd1 << I);
            end else begin
                nx.rem = trial[8:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[s+1] <= 1'b0;
            end else if (en) begin
                cv_reg[s+1] <= cv_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                car_reg[s+1] <= nx;
            end
        end
    end

    dcar_t fin;
    logic [16:0] tc_next, tc_reg, tb_reg, t2c_reg, t2b_reg, sc, sb, cov_reg, bf_reg;
    logic [17:0] kc_reg, kb_reg;
    logic t0v_reg, t1v_reg, t2v_reg;
    acps_pkg::side_t t0side_reg, t1side_reg, t2side_reg;

    assign fin = car_reg[DIV_STEPS];

    always_comb begin
        if (fin.side.mode == acps_pkg::MODE_BORDER) begin
            tc_next = fin.over ? acps_pkg::ALPHA_ONE : {1'b0, fin.q};
        end else begin
            tc_next = fin.tf;
        end
    end

    assign sc = 17'((35'(t2c_reg) * 35'(kc_reg)) >> 16);
    assign sb = 17'((35'(t2b_reg) * 35'(kb_reg)) >> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0v_reg <= 1'b0;
            t1v_reg <= 1'b0;
            t2v_reg <= 1'b0;
        end else if (en) begin
            t0v_reg <= cv_reg[DIV_STEPS];
            t1v_reg <= t0v_reg;
            t2v_reg <= t1v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tc_reg     <= tc_next;
            tb_reg     <= fin.tb;
            t0side_reg <= fin.side;
            t2c_reg    <= 17'((34'(tc_reg) * 34'(tc_reg)) >> 16);
            t2b_reg    <= 17'((34'(tb_reg) * 34'(tb_reg)) >> 16);
            kc_reg     <= 18'd196608 - {tc_reg, 1'b0};
            kb_reg     <= 18'd196608 - {tb_reg, 1'b0};
            t1side_reg <= t0side_reg;
            cov_reg    <= acps_pkg::ALPHA_ONE - sc;
            bf_reg     <= sb;
            t2side_reg <= t1side_reg;
        end
    end

    assign out_valid = t2v_reg;
    assign out_side  = t2side_reg;
    assign out_cov   = cov_reg;
    assign out_bf    = bf_reg;

endmodule

[rtl/acps_blend.sv]
// Colour stage: border/fill mix, alpha scaling by 1/255 and blend over the background.
// Depends on acps_pkg.
module acps_blend (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  acps_pkg::side_t in_side,
    input  logic [16:0]     in_cov,
    input  logic [16:0]     in_bf,
    input  acps_pkg::cfg_t  cfg,
    output logic            out_valid,
    output logic [31:0]     out_pixel,
    output logic            out_changed,
    output acps_pkg::side_t out_side
);
    typedef struct packed {
        acps_pkg::side_t side;
        logic [23:0]     col;
        logic            paint;
    } bcar_t;

    bcar_t b0_next, b0_reg, b1_reg, b2_reg, b3_reg;
    logic [7:0]  ca_next, ca_reg;
    logic [16:0] cov_reg;
    logic [24:0] p1_reg, p2_reg;
    logic [40:0] pr_reg;
    logic [17:0] q0;
    logic [25:0] qm;
    logic [16:0] a_next, a_reg;
    logic [3:0]  v_reg;

    always_comb begin
        b0_next.side  = in_side;
        b0_next.paint = in_cov > acps_pkg::ALPHA_MIN;
        case (in_side.mode)
            acps_pkg::MODE_BOTH: begin
                b0_next.col = {acps_pkg::mix_byte(in_bf, cfg.fill[23:16], cfg.border[23:16]),
                               acps_pkg::mix_byte(in_bf, cfg.fill[15:8], cfg.border[15:8]),
                               acps_pkg::mix_byte(in_bf, cfg.fill[7:0], cfg.border[7:0])};
                ca_next = acps_pkg::mix_byte(in_bf, cfg.fill[31:24], cfg.border[31:24]);
            end
            acps_pkg::MODE_BORDER: begin
                b0_next.col = cfg.border[23:0];
                ca_next     = cfg.border[31:24];
            end
            default: begin
                b0_next.col = cfg.fill[23:0];
                ca_next     = cfg.fill[31:24];
            end
        endcase
    end

    assign q0     = pr_reg[40:23];
    assign qm     = {q0, 8'h00} - 26'(q0);
    assign a_next = (qm > 26'(p2_reg)) ? 17'(q0 - 18'd1) : 17'(q0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b0_reg  <= b0_next;
            ca_reg  <= ca_next;
            cov_reg <= in_cov;
            b1_reg  <= b0_reg;
            p1_reg  <= 25'(ca_reg) * 25'(cov_reg);
            b2_reg  <= b1_reg;
            p2_reg  <= p1_reg;
            pr_reg  <= 41'(p1_reg) * 41'(16'h8081);
            b3_reg  <= b2_reg;
            a_reg   <= a_next;
        end
    end

    logic [7:0]  bg_a, bg_r, bg_g, bg_b, nr, ng, nb;
    logic [16:0] na;
    logic [31:0] pix_next, pix_reg;
    logic        chg_next, chg_reg, ov_reg;
    acps_pkg::side_t oside_reg;

    always_comb begin
        if (cfg.order) begin
            {bg_b, bg_g, bg_r, bg_a} = b3_reg.side.bg;
        end else begin
            {bg_a, bg_r, bg_g, bg_b} = b3_reg.side.bg;
        end
        na = acps_pkg::ALPHA_ONE - a_reg;
        nr = acps_pkg::mix_byte(na, bg_r, b3_reg.col[23:16]);
        ng = acps_pkg::mix_byte(na, bg_g, b3_reg.col[15:8]);
        nb = acps_pkg::mix_byte(na, bg_b, b3_reg.col[7:0]);
        chg_next = b3_reg.side.go && b3_reg.paint;
        if (!chg_next) begin
            pix_next = b3_reg.side.bg;
        end else if (cfg.order) begin
            pix_next = {nb, ng, nr, bg_a};
        end else begin
            pix_next = {bg_a, nr, ng, nb};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= v_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg   <= pix_next;
            chg_reg   <= chg_next;
            oside_reg <= b3_reg.side;
        end
    end

    assign out_valid   = ov_reg;
    assign out_pixel   = pix_reg;
    assign out_changed = chg_reg;
    assign out_side    = oside_reg;

endmodule

[rtl/antialiased_circle_pixel_shader.sv]
// Throughput: one pixel per cycle while the second output buffer entry is empty; the
// square root and the border divider are fully pipelined, one bit per stage. A two-entry
// output buffer lets the whole pipeline hold on one enable; input closes only while the
// second entry holds a result.
// Reset: aresetn synchronous, active low; clears all valid bits, including those of the
// output buffer, and the configuration registers to zero.
module antialiased_circle_pixel_shader #(
    parameter int COORD_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12], background_pixel[55:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_x[11:0], out_y[23:12], shaded_pixel[55:24]
    output logic [0:0]  m_tuser,   // write_back[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CW = (COORD_BITS < 12) ? COORD_BITS : 12;

    acps_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                acps_pkg::REG_CENTER_X:      cfg_reg.cx      <= cfg_data[11:0];
                acps_pkg::REG_CENTER_Y:      cfg_reg.cy      <= cfg_data[11:0];
                acps_pkg::REG_RADIUS:        cfg_reg.radius  <= cfg_data[11:0];
                acps_pkg::REG_THICKNESS:     cfg_reg.thick   <= cfg_data[7:0];
                acps_pkg::REG_FILL_ARGB:     cfg_reg.fill    <= cfg_data;
                acps_pkg::REG_BORDER_ARGB:   cfg_reg.border  <= cfg_data;
                acps_pkg::REG_PAINT_ENABLES: cfg_reg.enables <= cfg_data[1:0];
                acps_pkg::REG_PIXEL_ORDER:   cfg_reg.order   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic en;
    acps_pkg::side_t in_side, d_side, c_side, b_side;
    logic d_valid, c_valid, b_valid, b_changed;
    logic signed [COORD_BITS+9:0] d_dist;
    logic [16:0] c_cov, c_bf;
    logic [31:0] b_pixel;

    always_comb begin
        in_side.x    = 12'(s_tdata[CW-1:0]);
        in_side.y    = 12'(s_tdata[12+CW-1:12]);
        in_side.bg   = s_tdata[55:24];
        in_side.go   = 1'b0;
        in_side.mode = acps_pkg::MODE_FILL;
    end

    acps_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid && s_tready), .in_side(in_side), .cfg(cfg_reg),
        .out_valid(d_valid), .out_side(d_side), .out_d(d_dist)
    );

    acps_cover #(.COORD_BITS(COORD_BITS)) u_cover (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d_valid), .in_side(d_side), .in_d(d_dist), .cfg(cfg_reg),
        .out_valid(c_valid), .out_side(c_side), .out_cov(c_cov), .out_bf(c_bf)
    );

    acps_blend u_blend (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c_valid), .in_side(c_side), .in_cov(c_cov), .in_bf(c_bf), .cfg(cfg_reg),
        .out_valid(b_valid), .out_pixel(b_pixel), .out_changed(b_changed), .out_side(b_side)
    );

    logic [55:0] pipe_data;
    logic        m_valid_reg, sk_valid_reg, m_user_reg, sk_user_reg;
    logic [55:0] m_data_reg, sk_data_reg;

    assign pipe_data = {b_pixel, b_side.y, b_side.x};
    assign en        = !sk_valid_reg;
    assign s_tready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (sk_valid_reg) begin
            if (m_tready) begin
                sk_valid_reg <= 1'b0;
            end
        end else if (m_valid_reg && !m_tready) begin
            sk_valid_reg <= b_valid;
        end else begin
            m_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sk_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= sk_data_reg;
                m_user_reg <= sk_user_reg;
            end
        end else if (m_valid_reg && !m_tready) begin
            sk_data_reg <= pipe_data;
            sk_user_reg <= b_changed;
        end else begin
            m_data_reg <= pipe_data;
            m_user_reg <= b_changed;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

[rtl/acps_checker.sv]
// Port-level checks for the antialiased circle shader, bound to the top level.
// Depends on antialiased_circle_pixel_shader port names only.
module acps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_ready
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result request changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready && cfg_ready)
        else $error("not empty after reset");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input held off with no result pending");

endmodule

bind antialiased_circle_pixel_shader acps_checker u_acps_checker (.*);

[verif/antialiased_circle_pixel_shader_test.sv]
// Self-checking testbench for the antialiased circle pixel shader.
// Predicts each shaded pixel in fixed point and compares it with the result stream.
// Depends on acps_pkg and the antialiased_circle_pixel_shader top level.
`timescale 1ns / 1ps

module antialiased_circle_pixel_shader_test;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [31:0] pix;
        logic        changed;
    } shade_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    acps_pkg::cfg_t circle;
    shade_t shade_queue[$];
    int     mismatches = 0;
    bit     quiet = 1'b0;

    antialiased_circle_pixel_shader dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint unsigned smoothstep(input longint num, input longint den);
        longint t;
        longint unsigned t2;
        t = (num <= 0) ? 0 : (num * 256) / den;
        if (t > 65536) t = 65536;
        t2 = (t * t) >> 16;
        return (t2 * (3 * 65536 - 2 * t)) >> 16;
    endfunction

    function automatic logic [7:0] blend(input longint unsigned k, input logic [7:0] a,
                                         input logic [7:0] b);
        longint unsigned s;
        s = k * a + (65536 - k) * b;
        return s[23:16];
    endfunction

    function automatic shade_t shade(input logic [11:0] px, input logic [11:0] py,
                                     input logic [31:0] bg);
        shade_t res;
        longint r, bw, rx, ry, d, ad;
        longint unsigned cov, bf, a;
        logic [7:0] ca, cr, cg, cb, ba, br, bgc, bb;
        bit fill_on, border_on;
        res = '{px, py, bg, 1'b0};
        r = longint'(circle.radius);
        bw = longint'(circle.thick);
        fill_on = circle.enables[0];
        border_on = circle.enables[1] && bw > 0;
        if (circle.order) {bb, bgc, br, ba} = bg;
        else {ba, br, bgc, bb} = bg;
        if (!(fill_on || border_on)) return res;
        if (longint'(px) < longint'(circle.cx) - r - 2 || longint'(px) > circle.cx + r + 2 ||
            longint'(py) < longint'(circle.cy) - r - 2 || longint'(py) > circle.cy + r + 2)
            return res;
        rx = (longint'(px) - longint'(circle.cx)) * 256 + 128;
        ry = (longint'(py) - longint'(circle.cy)) * 256 + 128;
        d = isqrt(rx * rx + ry * ry) - r * 256;
        if (border_on && fill_on) begin
            cov = 65536 - smoothstep(d + 128, 1);
            bf = smoothstep(d + bw * 256 + 128, 1);
            ca = blend(bf, circle.fill[31:24], circle.border[31:24]);
            cr = blend(bf, circle.fill[23:16], circle.border[23:16]);
            cg = blend(bf, circle.fill[15:8], circle.border[15:8]);
            cb = blend(bf, circle.fill[7:0], circle.border[7:0]);
        end else if (border_on) begin
            ad = d < 0 ? -d : d;
            cov = 65536 - smoothstep(ad + bw * 128 + 128, bw + 1);
            {ca, cr, cg, cb} = circle.border;
        end else begin
            cov = 65536 - smoothstep(d + 128, 1);
            {ca, cr, cg, cb} = circle.fill;
        end
        if (cov <= 655) return res;
        a = (ca * cov) / 255;
        br = blend(65536 - a, br, cr);
        bgc = blend(65536 - a, bgc, cg);
        bb = blend(65536 - a, bb, cb);
        res.pix = circle.order ? {bb, bgc, br, ba} : {ba, br, bgc, bb};
        res.changed = 1'b1;
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        shade_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (shade_queue.size() == 0) begin
                report("unexpected result", m_tdata[31:0], '0);
            end else begin
                want = shade_queue.pop_front();
                if (m_tdata[11:0] != want.x)
                    report("out_x", 32'(m_tdata[11:0]), 32'(want.x));
                if (m_tdata[23:12] != want.y)
                    report("out_y", 32'(m_tdata[23:12]), 32'(want.y));
                if (m_tdata[55:24] != want.pix)
                    report("shaded_pixel", m_tdata[55:24], want.pix);
                if (m_tuser[0] != want.changed)
                    report("write_back", 32'(m_tuser), 32'(want.changed));
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0 && !quiet) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            acps_pkg::REG_CENTER_X:      circle.cx = val[11:0];
            acps_pkg::REG_CENTER_Y:      circle.cy = val[11:0];
            acps_pkg::REG_RADIUS:        circle.radius = val[11:0];
            acps_pkg::REG_THICKNESS:     circle.thick = val[7:0];
            acps_pkg::REG_FILL_ARGB:     circle.fill = val;
            acps_pkg::REG_BORDER_ARGB:   circle.border = val;
            acps_pkg::REG_PAINT_ENABLES: circle.enables = val[1:0];
            default:                     circle.order = val[0];
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (shade_queue.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_circle(input logic [11:0] cx, input logic [11:0] cy,
                              input logic [11:0] r, input logic [7:0] th,
                              input logic [31:0] fill, input logic [31:0] border,
                              input logic [1:0] en, input logic order);
        drain();
        write_reg(acps_pkg::REG_CENTER_X, 32'(cx));
        write_reg(acps_pkg::REG_CENTER_Y, 32'(cy));
        write_reg(acps_pkg::REG_RADIUS, 32'(r));
        write_reg(acps_pkg::REG_THICKNESS, 32'(th));
        write_reg(acps_pkg::REG_FILL_ARGB, fill);
        write_reg(acps_pkg::REG_BORDER_ARGB, border);
        write_reg(acps_pkg::REG_PAINT_ENABLES, 32'(en));
        write_reg(acps_pkg::REG_PIXEL_ORDER, 32'(order));
    endtask

    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                              input logic [31:0] bg);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {bg, py, px};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        shade_queue.push_back(shade(px, py, bg));
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // pixel near the circle, sometimes anywhere
    task automatic random_pixels(input int n);
        int span;
        logic [11:0] px, py;
        span = circle.radius + circle.thick + 4;
        if (span > 2047) span = 2047;
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                px = 12'($urandom);
                py = 12'($urandom);
            end else begin
                px = circle.cx + 12'($urandom_range(0, 2 * span) - span);
                py = circle.cy + 12'($urandom_range(0, 2 * span) - span);
            end
            send_pixel(px, py, $urandom);
        end
        idle_input();
    endtask

    task automatic test_reset_defaults();
        circle = '0;
        send_pixel(12'd0, 12'd0, 32'h12345678);
        send_pixel(12'hFFF, 12'hFFF, 32'hFFFFFFFF);
        idle_input();
    endtask

    task automatic test_directed();
        set_circle(12'd20, 12'd20, 12'd8, 8'd2, 32'hFF_FF_00_00, 32'h80_00_FF_FF, 2'd3, 1'b0);
        send_pixel(12'd20, 12'd20, 32'h00000000);
        send_pixel(12'd28, 12'd20, 32'hFFFFFFFF);
        send_pixel(12'd26, 12'd20, 32'hA5A5A5A5);
        send_pixel(12'd30, 12'd20, 32'h5A5A5A5A);
        send_pixel(12'd31, 12'd20, 32'h11223344);
        send_pixel(12'd0, 12'd0, 32'h11223344);
        send_pixel(12'd20, 12'd9, 32'hFFFFFFFF);
        idle_input();
        set_circle(12'd20, 12'd20, 12'd8, 8'd3, 32'h0, 32'hFF_10_20_30, 2'd2, 1'b1);
        send_pixel(12'd28, 12'd20, 32'h44332211);
        send_pixel(12'd20, 12'd20, 32'h44332211);
        send_pixel(12'd24, 12'd24, 32'hFFFFFFFF);
        send_pixel(12'd30, 12'd21, 32'h00000000);
        idle_input();
        set_circle(12'd0, 12'd0, 12'd0, 8'd0, 32'hFFFFFFFF, 32'h0, 2'd2, 1'b0);
        send_pixel(12'd0, 12'd0, 32'h00000000);
        idle_input();
        set_circle(12'd0, 12'd0, 12'd0, 8'd0, 32'hFFFFFFFF, 32'h0, 2'd1, 1'b0);
        send_pixel(12'd0, 12'd0, 32'h00000000);
        send_pixel(12'd2, 12'd2, 32'h00000000);
        send_pixel(12'd3, 12'd0, 32'h00000000);
        idle_input();
        set_circle(12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3, 1'b1);
        send_pixel(12'hFFF, 12'hFFF, 32'h00000000);
        send_pixel(12'd0, 12'd0, 32'hFFFFFFFF);
        send_pixel(12'hFFF, 12'd0, 32'h80808080);
        idle_input();
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        logic [11:0] r;
        repeat (phases) begin
            r = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
            set_circle(12'($urandom), 12'($urandom), r,
                       ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)),
                       $urandom, $urandom, 2'($urandom), 1'($urandom));
            random_pixels(per_phase);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed();
        test_random_settings(30, 40);
        quiet = 1'b1;
        test_random_settings(5, 40);
        drain();
        if (mismatches == 0 && shade_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[antialiased_circle_pixel_shader.f]
rtl/acps_pkg.sv
rtl/acps_dist.sv
rtl/acps_cover.sv
rtl/acps_blend.sv
rtl/antialiased_circle_pixel_shader.sv
rtl/acps_checker.sv
verif/antialiased_circle_pixel_shader_test.sv
